[design/oam_dma_pkg.sv]
`timescale 1ns / 1ps
// oam_dma_pkg: shared types and constants of the sprite-table dma sequencer
// no dependencies; used by every module of the block

package oam_dma_pkg;

    // sprite table size in bytes and restart delay in ticks
    localparam int TABLE_BYTES   = 160;
    localparam int RESTART_DELAY = 3;

    localparam logic [15:0] PAGE_REG_ADDR = 16'hFF46;
    localparam logic [15:0] TABLE_BASE    = 16'hFE00;

    // table end as a 17-bit bound, copy count bound as 9 bits
    localparam logic [16:0] TABLE_END   = 17'({1'b0, TABLE_BASE}) + 17'(TABLE_BYTES);
    localparam logic [8:0]  TABLE_COUNT = 9'(TABLE_BYTES);
    localparam logic [1:0]  RESTART_VAL = 2'(RESTART_DELAY);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        PH_STOP = 3'd0,
        PH_M1   = 3'd1,
        PH_M2   = 3'd2,
        PH_INIT = 3'd3,
        PH_RUN  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] cpu_address;
        logic [7:0]  write_data;
    } t_item;

    typedef struct packed {
        logic        copy_valid;
        logic [15:0] copy_source_address;
        logic [7:0]  copy_oam_offset;
        logic        dma_active;
        logic        access_blocked;
        logic [7:0]  page_readback;
    } t_result;

endpackage

[design/oam_dma_in_stage.sv]
`timescale 1ns / 1ps
// oam_dma_in_stage: input register holding one accepted item
// depends on oam_dma_pkg

module oam_dma_in_stage
    import oam_dma_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // free when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[design/oam_dma_engine.sv]
`timescale 1ns / 1ps
// oam_dma_engine: dma phase state and single-pass next-state / result logic
// depends on oam_dma_pkg

module oam_dma_engine
    import oam_dma_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    output t_result o_result
);

    t_phase      r_phase,   n_phase;
    logic [7:0]  r_offset,  n_offset;
    logic        r_running, n_running;
    logic [1:0]  r_cd,      n_cd;
    logic [7:0]  r_latched, n_latched;
    logic [7:0]  r_page,    n_page;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_STOP;
            r_offset  <= '0;
            r_running <= 1'b0;
            r_cd      <= '0;
            r_latched <= '0;
            r_page    <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_offset  <= n_offset;
            r_running <= n_running;
            r_cd      <= n_cd;
            r_latched <= n_latched;
            r_page    <= n_page;
        end
    end

    always_comb begin
        logic       in_table;
        logic [8:0] next_off;
        t_phase     ph;

        n_phase   = r_phase;
        n_offset  = r_offset;
        n_running = r_running;
        n_cd      = r_cd;
        n_latched = r_latched;
        n_page    = r_page;
        ph        = r_phase;
        next_off  = 9'({1'b0, r_offset}) + 9'd1;
        in_table  = ({1'b0, i_item.cpu_address} >= {1'b0, TABLE_BASE})
                 && ({1'b0, i_item.cpu_address} < TABLE_END);

        o_result = '0;

        case (i_item.operation)
            OP_WRITE, OP_READ: begin
                o_result.access_blocked = r_running && in_table;
                if (i_item.operation == OP_WRITE && i_item.cpu_address == PAGE_REG_ADDR) begin
                    if (r_phase == PH_STOP) begin
                        n_phase = PH_M1;
                    end else begin
                        n_cd = RESTART_VAL;
                    end
                    n_page = i_item.write_data;
                end
            end
            OP_TICK: begin
                // restart countdown runs first and may force init
                if (r_cd != 2'd0) begin
                    n_cd = r_cd - 2'd1;
                    if (r_cd == 2'd1) begin
                        ph = PH_INIT;
                    end
                end
                n_phase = ph;
                case (ph)
                    PH_M1: n_phase = PH_M2;
                    PH_M2: n_phase = PH_INIT;
                    PH_INIT, PH_RUN: begin
                        logic [7:0] cur_off;
                        logic [7:0] cur_page;
                        cur_off  = r_offset;
                        cur_page = r_latched;
                        if (ph == PH_INIT) begin
                            cur_off   = '0;
                            cur_page  = r_page;
                            n_latched = r_page;
                            n_running = 1'b1;
                        end
                        n_phase  = PH_RUN;
                        next_off = 9'({1'b0, cur_off}) + 9'd1;
                        o_result.copy_valid          = 1'b1;
                        o_result.copy_source_address = {cur_page, cur_off};
                        o_result.copy_oam_offset     = cur_off;
                        if (next_off >= TABLE_COUNT) begin
                            n_phase   = PH_STOP;
                            n_offset  = '0;
                            n_running = 1'b0;
                        end else begin
                            n_offset = next_off[7:0];
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        o_result.dma_active    = n_running;
        o_result.page_readback = n_page;
    end

`ifndef NO_ASSERTIONS
    // the running flag and the run phase always move together
    a_run_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running == (r_phase == PH_RUN))
        else $error("running flag out of step with phase");

    // the copy offset never reaches the end of the table
    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_offset} < TABLE_COUNT)
        else $error("copy offset beyond table");

    // the countdown never exceeds its load value
    a_cd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cd <= RESTART_VAL)
        else $error("restart countdown out of range");

    // a copy reported with dma active leaves the engine running after the item
    a_copy_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.copy_valid && o_result.dma_active) |=> r_running)
        else $error("copy reported but engine not running");
`endif

endmodule

[design/oam_dma_out_stage.sv]
`timescale 1ns / 1ps
// oam_dma_out_stage: result register toward the downstream receiver
// depends on oam_dma_pkg

module oam_dma_out_stage
    import oam_dma_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[design/oam_dma_sequencer.sv]
`timescale 1ns / 1ps
// oam_dma_sequencer: top level of the sprite-table dma sequencer
// depends on oam_dma_pkg, oam_dma_in_stage, oam_dma_engine, oam_dma_out_stage
//
// usage:
//   slave channel takes one item per transfer: a cpu write, a cpu read or a
//   machine-cycle tick (operation in tuser); address and write byte in tdata
//   master channel returns exactly one result per item, in order: the copy
//   this tick performs (valid flag in tuser, source address and table offset
//   in tdata), the dma active flag, the access blocked flag and the page
//   register readback
//   an accepted item waits in the input register; its result is loaded into the
//   output register once that register is empty or drains
//   throughput: one item per clock unless the receiver stalls; the single-pass
//   engine logic between the registers updates all state at once, back to back
//   reset (i_rst_n low at a clock edge) stops the engine, clears the page
//   register, countdown and offsets, and empties both registers
//   stall: when i_m_axis_tready is low the result holds; one more item is
//   taken into the input register, after which o_s_axis_tready drops
//   the host performs the byte move and answers blocked reads with 0xFF

module oam_dma_sequencer
    import oam_dma_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [15:0] cpu_address, [23:16] write_data
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] operation
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [15:0] copy_source_address,
                                          // [23:16] copy_oam_offset, [24] dma_active,
                                          // [25] access_blocked, [33:26] page_readback,
                                          // [39:34] zero
    output logic [0:0]  o_m_axis_tuser    // [0] copy_valid
);

    t_item   in_item;
    t_item   held_item;
    t_result eng_result;
    t_result out_result;
    logic    held_valid;
    logic    out_valid;
    logic    step;

    // unpack the incoming transfer
    assign in_item.operation   = i_s_axis_tuser;
    assign in_item.cpu_address = i_s_axis_tdata[15:0];
    assign in_item.write_data  = i_s_axis_tdata[23:16];

    // held item advances when the result register is empty or drains now
    assign step = held_valid && (!out_valid || i_m_axis_tready);

    oam_dma_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .i_take  (step),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    // state only moves when the item's result is captured
    oam_dma_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (held_item),
        .o_result (eng_result)
    );

    oam_dma_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (eng_result),
        .i_ready  (i_m_axis_tready),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    // pack the outgoing transfer
    assign o_m_axis_tvalid = out_valid;
    assign o_m_axis_tuser  = out_result.copy_valid;
    assign o_m_axis_tdata  = {6'd0,
                              out_result.page_readback,
                              out_result.access_blocked,
                              out_result.dma_active,
                              out_result.copy_oam_offset,
                              out_result.copy_source_address};

`ifndef NO_ASSERTIONS
    // a result register entry is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !i_m_axis_tready) |-> !step)
        else $error("result overwritten while stalled");

    // an engine step always delivers a result next cycle
    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> out_valid)
        else $error("stepped item produced no result");

    // input side is ready whenever the input register is empty
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !held_valid |-> o_s_axis_tready)
        else $error("input stalled while empty");
`endif

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking testbench of the sprite-table dma sequencer
// depends on oam_dma_pkg and oam_dma_sequencer; a built-in predictor checks every result

module tb_top;
    import oam_dma_pkg::*;

    // operation code the block does not define, still legal on the bus
    localparam logic [1:0] OP_UNUSED      = 2'd3;
    // cycles with no transfer on either side before the run is abandoned
    localparam int         WATCHDOG_LIMIT = 2000;
    // two register stages plus margin
    localparam int         DRAIN_CYCLES   = 6;
    localparam int         PRINT_LIMIT    = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;   // [15:0] cpu_address, [23:16] write_data
    logic [1:0]  i_s_axis_tuser = '0;   // [1:0] operation
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;        // [15:0] source, [23:16] offset, [24] active,
                                        // [25] blocked, [33:26] page, [39:34] zero
    logic [0:0]  o_m_axis_tuser;        // [0] copy_valid

    oam_dma_sequencer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state, mirrors the engine
    t_phase     dma_phase;
    logic [7:0] copy_off;
    logic       pred_running;
    logic [1:0] restart_count;
    logic [7:0] src_page;
    logic [7:0] page_reg;

    t_result    expected_results[$];
    int         error_count = 0;
    int         results_seen = 0;
    int         items_sent = 0;
    int         src_idle_pct = 0;
    int         snk_idle_pct = 0;
    int         quiet_cycles = 0;

    // one item through the predictor: updates state and returns the result
    function automatic t_result predict_dma_step(logic [1:0] op, logic [15:0] addr,
                                                 logic [7:0] data);
        t_result     r;
        int unsigned next_off;
        r = '0;
        if (op == OP_WRITE || op == OP_READ) begin
            // blocked only while running and inside the sprite table
            r.access_blocked = pred_running && ({1'b0, addr} >= {1'b0, TABLE_BASE})
                               && ({1'b0, addr} < TABLE_END);
            if (op == OP_WRITE && addr == PAGE_REG_ADDR) begin
                // from stop: start delay; otherwise arm the restart countdown
                if (dma_phase == PH_STOP)
                    dma_phase = PH_M1;
                else
                    restart_count = RESTART_VAL;
                page_reg = data;
            end
        end else if (op == OP_TICK) begin
            if (restart_count != 2'd0) begin
                if (restart_count == 2'd1)
                    dma_phase = PH_INIT;
                restart_count = restart_count - 2'd1;
            end
            case (dma_phase)
                PH_M1: begin
                    dma_phase = PH_M2;
                end
                PH_M2: begin
                    dma_phase = PH_INIT;
                end
                PH_INIT, PH_RUN: begin
                    // init latches the page and does the first copy on the same tick
                    if (dma_phase == PH_INIT) begin
                        src_page     = page_reg;
                        dma_phase    = PH_RUN;
                        pred_running = 1'b1;
                        copy_off     = 8'd0;
                    end
                    r.copy_valid          = 1'b1;
                    r.copy_source_address = {src_page, 8'h00} + 16'(copy_off);
                    r.copy_oam_offset     = copy_off;
                    next_off = 32'(copy_off) + 1;
                    if (next_off >= TABLE_BYTES || next_off > 255) begin
                        dma_phase    = PH_STOP;
                        copy_off     = 8'd0;
                        pred_running = 1'b0;
                    end else begin
                        copy_off = 8'(next_off);
                    end
                end
                default: ;
            endcase
        end
        r.dma_active    = pred_running;
        r.page_readback = page_reg;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
        error_count++;
    endtask

    // one transfer on the slave side; prediction taken at acceptance
    task automatic send_item(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {data, addr};
        i_s_axis_tuser  <= op;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        expected_results.push_back(predict_dma_step(op, addr, data));
        items_sent++;
    endtask

    // receiver stalls at the current rate
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // result checker: compare each transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result tdata %h tuser %h",
                                          o_m_axis_tdata, o_m_axis_tuser));
            end else begin
                exp_r = expected_results.pop_front();
                if (o_m_axis_tuser[0] !== exp_r.copy_valid)
                    report_mismatch($sformatf("copy_valid got %b expected %b",
                                              o_m_axis_tuser[0], exp_r.copy_valid));
                if (o_m_axis_tdata[15:0] !== exp_r.copy_source_address)
                    report_mismatch($sformatf("copy_source_address got %h expected %h",
                                              o_m_axis_tdata[15:0],
                                              exp_r.copy_source_address));
                if (o_m_axis_tdata[23:16] !== exp_r.copy_oam_offset)
                    report_mismatch($sformatf("copy_oam_offset got %h expected %h",
                                              o_m_axis_tdata[23:16], exp_r.copy_oam_offset));
                if (o_m_axis_tdata[24] !== exp_r.dma_active)
                    report_mismatch($sformatf("dma_active got %b expected %b",
                                              o_m_axis_tdata[24], exp_r.dma_active));
                if (o_m_axis_tdata[25] !== exp_r.access_blocked)
                    report_mismatch($sformatf("access_blocked got %b expected %b",
                                              o_m_axis_tdata[25], exp_r.access_blocked));
                if (o_m_axis_tdata[33:26] !== exp_r.page_readback)
                    report_mismatch($sformatf("page_readback got %h expected %h",
                                              o_m_axis_tdata[33:26], exp_r.page_readback));
                if (o_m_axis_tdata[39:34] !== 6'd0)
                    report_mismatch($sformatf("padding bits got %h", o_m_axis_tdata[39:34]));
            end
            results_seen++;
        end
    end

    // watchdog: ends the run after too many cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // cpu accesses while stopped: nothing blocked, other registers ignored
    task automatic test_idle_accesses();
        send_item(OP_READ, TABLE_BASE, 8'h00);
        send_item(OP_WRITE, TABLE_BASE + 16'(TABLE_BYTES - 1), 8'h00);
        send_item(OP_READ, 16'(TABLE_END), 8'hFF);
        send_item(OP_UNUSED, 16'hFFFF, 8'hFF);
        send_item(OP_WRITE, PAGE_REG_ADDR - 16'd1, 8'hFF);
        send_item(OP_TICK, 16'hFFFF, 8'hFF);
    endtask

    // start delay, then a page write during the delay arms the restart countdown
    task automatic test_start_and_restart();
        send_item(OP_WRITE, PAGE_REG_ADDR, 8'h00);
        send_item(OP_TICK, 16'h0000, 8'h00);
        send_item(OP_WRITE, PAGE_REG_ADDR, 8'hFF);
        repeat (4) send_item(OP_TICK, 16'h0000, 8'h00);
    endtask

    // accesses while running: table edges, just outside, and a restart mid-copy
    task automatic test_running_accesses();
        send_item(OP_READ, TABLE_BASE, 8'h00);
        send_item(OP_WRITE, TABLE_BASE + 16'(TABLE_BYTES - 1), 8'hA5);
        send_item(OP_READ, 16'(TABLE_END), 8'h00);
        send_item(OP_READ, TABLE_BASE - 16'd1, 8'h00);
        send_item(OP_UNUSED, TABLE_BASE, 8'h5A);
        send_item(OP_WRITE, PAGE_REG_ADDR, 8'h80);
        repeat (3) send_item(OP_TICK, 16'hFFFF, 8'hFF);
        send_item(OP_READ, 16'h0000, 8'h00);
    endtask

    // cpu access with the address biased toward the sprite table and its edges
    task automatic send_cpu_access();
        logic [1:0]  op;
        logic [15:0] addr;
        int          sel;
        op  = $urandom_range(1) ? OP_READ : OP_WRITE;
        sel = $urandom_range(9);
        case (sel)
            0, 1, 2, 3, 4: addr = TABLE_BASE + 16'($urandom_range(TABLE_BYTES - 1));
            5:             addr = TABLE_BASE - 16'd1;
            6:             addr = 16'(TABLE_END);
            7:             addr = TABLE_BASE + 16'(TABLE_BYTES - 1);
            default:       addr = 16'($urandom);
        endcase
        send_item(op, addr, 8'($urandom));
    endtask

    // mostly full transfers with traffic in between, some raw noise
    task automatic test_random_sequences(int n_items, int src_pct, int snk_pct);
        int target;
        int steps;
        int roll;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(9) < 8) begin
                send_item(OP_WRITE, PAGE_REG_ADDR, 8'($urandom));
                // long bursts run the copy to its end, short ones cut it off
                steps = $urandom_range(1) ? $urandom_range(200, 260) : $urandom_range(10, 120);
                repeat (steps) begin
                    if (items_sent >= target)
                        break;
                    roll = $urandom_range(99);
                    if (roll < 80)
                        send_item(OP_TICK, 16'($urandom), 8'($urandom));
                    else if (roll < 81)
                        send_item(OP_WRITE, PAGE_REG_ADDR, 8'($urandom));
                    else if (roll < 84)
                        send_item(OP_UNUSED, 16'($urandom), 8'($urandom));
                    else
                        send_cpu_access();
                end
            end else begin
                repeat ($urandom_range(3, 12)) begin
                    if (items_sent >= target)
                        break;
                    send_item(2'($urandom_range(3)),
                              $urandom_range(7) == 0 ? PAGE_REG_ADDR : 16'($urandom),
                              8'($urandom));
                end
            end
        end
    endtask

    initial begin
        // predictor reset state
        dma_phase     = PH_STOP;
        copy_off      = '0;
        pred_running  = 1'b0;
        restart_count = '0;
        src_page      = '0;
        page_reg      = '0;
        src_idle_pct  = 21;
        snk_idle_pct  = 49;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_accesses();
        test_start_and_restart();
        test_running_accesses();
        test_random_sequences(283, 21, 49);
        test_random_sequences(283, 49, 21);
        test_random_sequences(284, 0, 0);

        i_s_axis_tvalid <= 1'b0;
        snk_idle_pct = 0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
design/oam_dma_pkg.sv
design/oam_dma_in_stage.sv
design/oam_dma_engine.sv
design/oam_dma_out_stage.sv
design/oam_dma_sequencer.sv
test/tb_top.sv
